FILE: src/ryc_pkg.sv
// ----------------------------------------------------------------------------
// ryc_pkg
// Shared types and constants for the RGB565 to YUV 4:2:0 scaler.
// ----------------------------------------------------------------------------
package ryc_pkg;

   // coordinate and fixed point widths
   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 16;
   localparam int ACC_BITS   = COORD_BITS + FRAC_BITS;
   localparam int SCALE_BITS = 24;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = SCALE_BITS;
   localparam int PIXEL_BITS = 16;

   localparam logic [SCALE_BITS-1:0] ONE_Q16 = 24'h01_0000;

   // configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_SOURCE_LINE_PIXELS = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CROP_WIDTH         = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CROP_HEIGHT        = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEST_WIDTH         = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEST_HEIGHT        = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCALE_Q16          = 3'd5;

   // one selected pixel waiting for conversion
   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic [COORD_BITS-1:0] dest_x;
      logic [COORD_BITS-1:0] dest_y;
   } queue_entry_type;

   // queue status seen by the front end
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: src/ryc_front.sv
// ----------------------------------------------------------------------------
// ryc_front
// Configuration registers, source/destination counters and nearest-neighbor
// selection; selected pixels are pushed into the queue.
// ----------------------------------------------------------------------------
module ryc_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [ryc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [ryc_pkg::CSR_DATA_BITS-1:0]   csr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ryc_pkg::PIXEL_BITS-1:0]      req_pixel_word,
   input  logic                                req_frame_last,
   input  ryc_pkg::queue_status_type           queue_status,
   output logic                                push_valid,
   output ryc_pkg::queue_entry_type            push_entry
);
   import ryc_pkg::*;

   logic [COORD_BITS-1:0] line_pixels_ff, crop_width_ff, crop_height_ff;
   logic [COORD_BITS-1:0] dest_width_ff, dest_height_ff;
   logic [SCALE_BITS-1:0] scale_ff;

   logic [COORD_BITS-1:0] src_col_ff, src_col_in, src_row_ff, src_row_in;
   logic [COORD_BITS-1:0] dst_col_ff, dst_col_in, dst_row_ff, dst_row_in;
   logic [ACC_BITS-1:0]   acc_col_ff, acc_col_in, acc_row_ff, acc_row_in;

   logic [SCALE_BITS-1:0] step;
   logic [COORD_BITS-1:0] line;
   logic                  row_hit, col_hit, hit, accept, line_end;
   logic [ACC_BITS:0]     col_sum, row_sum;
   logic [ACC_BITS-1:0]   col_acc_next, row_acc_next;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         line_pixels_ff <= 12'd320;
         crop_width_ff  <= 12'd320;
         crop_height_ff <= 12'd240;
         dest_width_ff  <= 12'd320;
         dest_height_ff <= 12'd240;
         scale_ff       <= ONE_Q16;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SOURCE_LINE_PIXELS: line_pixels_ff <= csr_data[COORD_BITS-1:0];
            CSR_CROP_WIDTH:         crop_width_ff  <= csr_data[COORD_BITS-1:0];
            CSR_CROP_HEIGHT:        crop_height_ff <= csr_data[COORD_BITS-1:0];
            CSR_DEST_WIDTH:         dest_width_ff  <= csr_data[COORD_BITS-1:0];
            CSR_DEST_HEIGHT:        dest_height_ff <= csr_data[COORD_BITS-1:0];
            CSR_SCALE_Q16:          scale_ff       <= csr_data[SCALE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // selection and counter update
   always_comb begin
      step = (scale_ff < ONE_Q16) ? ONE_Q16 : scale_ff;
      line = (line_pixels_ff == '0) ? COORD_BITS'(1) : line_pixels_ff;

      row_hit = (src_row_ff == acc_row_ff[ACC_BITS-1:FRAC_BITS])
              && (dst_row_ff < dest_height_ff) && (src_row_ff < crop_height_ff);
      col_hit = (src_col_ff == acc_col_ff[ACC_BITS-1:FRAC_BITS])
              && (dst_col_ff < dest_width_ff) && (src_col_ff < crop_width_ff);
      hit = row_hit && col_hit;

      // saturating accumulator adds
      col_sum = {1'b0, acc_col_ff} + {{(ACC_BITS+1-SCALE_BITS){1'b0}}, step};
      row_sum = {1'b0, acc_row_ff} + {{(ACC_BITS+1-SCALE_BITS){1'b0}}, step};
      col_acc_next = col_sum[ACC_BITS] ? {ACC_BITS{1'b1}} : col_sum[ACC_BITS-1:0];
      row_acc_next = row_sum[ACC_BITS] ? {ACC_BITS{1'b1}} : row_sum[ACC_BITS-1:0];

      line_end = ({1'b0, src_col_ff} + (COORD_BITS+1)'(1)) >= {1'b0, line};

      req_ready = !queue_status.full;
      accept    = req_valid && req_ready;

      src_col_in = src_col_ff;
      src_row_in = src_row_ff;
      dst_col_in = dst_col_ff;
      dst_row_in = dst_row_ff;
      acc_col_in = acc_col_ff;
      acc_row_in = acc_row_ff;

      if (accept) begin
         if (hit) begin
            dst_col_in = dst_col_ff + COORD_BITS'(1);
            acc_col_in = col_acc_next;
         end
         if (req_frame_last) begin
            src_col_in = '0;
            src_row_in = '0;
            dst_col_in = '0;
            dst_row_in = '0;
            acc_col_in = '0;
            acc_row_in = '0;
         end else if (line_end) begin
            src_col_in = '0;
            dst_col_in = '0;
            acc_col_in = '0;
            if (row_hit) begin
               dst_row_in = dst_row_ff + COORD_BITS'(1);
               acc_row_in = row_acc_next;
            end
            // row counter holds at its maximum
            if (src_row_ff != {COORD_BITS{1'b1}}) begin
               src_row_in = src_row_ff + COORD_BITS'(1);
            end
         end else begin
            src_col_in = src_col_ff + COORD_BITS'(1);
         end
      end

      push_valid        = accept && hit;
      push_entry.pixel  = req_pixel_word;
      push_entry.dest_x = dst_col_ff;
      push_entry.dest_y = dst_row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff <= '0;
         src_row_ff <= '0;
         dst_col_ff <= '0;
         dst_row_ff <= '0;
         acc_col_ff <= '0;
         acc_row_ff <= '0;
      end else begin
         src_col_ff <= src_col_in;
         src_row_ff <= src_row_in;
         dst_col_ff <= dst_col_in;
         dst_row_ff <= dst_row_in;
         acc_col_ff <= acc_col_in;
         acc_row_ff <= acc_row_in;
      end
   end

endmodule

FILE: src/ryc_queue.sv
// ----------------------------------------------------------------------------
// ryc_queue
// Small FIFO of selected pixels between the front end and the converter.
// ----------------------------------------------------------------------------
module ryc_queue #(
   parameter int DEPTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   input  ryc_pkg::queue_entry_type    push_entry,
   output ryc_pkg::queue_status_type   status,
   input  logic                        pop,
   output ryc_pkg::queue_entry_type    head
);
   import ryc_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   queue_entry_type       store_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]     count_ff, count_in;
   logic                  do_push, do_pop;

   // pointer and count update
   always_comb begin
      status.full  = (count_ff == (PTR_BITS+1)'(DEPTH));
      status.empty = (count_ff == '0);
      do_push = push_valid && !status.full;
      do_pop  = pop && !status.empty;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH-1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH-1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      count_in = count_ff + (PTR_BITS+1)'(do_push) - (PTR_BITS+1)'(do_pop);

      head = store_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: src/ryc_back.sv
// ----------------------------------------------------------------------------
// ryc_back
// BT.601 color conversion of queued pixels into the result register.
// ----------------------------------------------------------------------------
module ryc_back (
   input  logic                               clock,
   input  logic                               reset,
   input  ryc_pkg::queue_status_type          queue_status,
   input  ryc_pkg::queue_entry_type           head,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ryc_pkg::COORD_BITS-1:0]     rsp_dest_x,
   output logic [ryc_pkg::COORD_BITS-1:0]     rsp_dest_y,
   output logic [7:0]                         rsp_luma,
   output logic [7:0]                         rsp_chroma_blue,
   output logic [7:0]                         rsp_chroma_red
);
   import ryc_pkg::*;

   logic                  valid_ff;
   logic [COORD_BITS-1:0] dest_x_ff, dest_y_ff;
   logic [7:0]            luma_ff, cb_ff, cr_ff;
   logic [7:0]            luma_in, cb_in, cr_in;

   logic [7:0]            red, green, blue;
   logic signed [17:0]    r_s, g_s, b_s;
   logic signed [17:0]    y_sum, cb_sum, cr_sum;
   logic signed [17:0]    y_val, cb_val, cr_val;

   // clamp a signed value to 0..255
   function automatic logic [7:0] clamp8(input logic signed [17:0] v);
      logic [7:0] res;
      if (v < 0) begin
         res = 8'd0;
      end else if (v > 18'sd255) begin
         res = 8'd255;
      end else begin
         res = v[7:0];
      end
      return res;
   endfunction

   // unpack rgb565 and apply the conversion matrix
   always_comb begin
      red   = {head.pixel[15:11], 3'b000};
      green = {head.pixel[10:5], 2'b00};
      blue  = {head.pixel[4:0], 3'b000};
      r_s   = signed'({10'd0, red});
      g_s   = signed'({10'd0, green});
      b_s   = signed'({10'd0, blue});

      y_sum  = 18'sd66 * r_s + 18'sd129 * g_s + 18'sd25 * b_s + 18'sd128;
      cb_sum = 18'sd112 * b_s - 18'sd38 * r_s - 18'sd74 * g_s + 18'sd128;
      cr_sum = 18'sd112 * r_s - 18'sd94 * g_s - 18'sd18 * b_s + 18'sd128;

      y_val  = (y_sum >>> 8) + 18'sd16;
      cb_val = (cb_sum >>> 8) + 18'sd128;
      cr_val = (cr_sum >>> 8) + 18'sd128;

      luma_in = clamp8(y_val);
      cb_in   = clamp8(cb_val);
      cr_in   = clamp8(cr_val);

      pop = !queue_status.empty && (!valid_ff || rsp_ready);
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         dest_x_ff <= head.dest_x;
         dest_y_ff <= head.dest_y;
         luma_ff   <= luma_in;
         cb_ff     <= cb_in;
         cr_ff     <= cr_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_dest_x      = dest_x_ff;
   assign rsp_dest_y      = dest_y_ff;
   assign rsp_luma        = luma_ff;
   assign rsp_chroma_blue = cb_ff;
   assign rsp_chroma_red  = cr_ff;

endmodule

FILE: src/rgb565_scaled_to_yuv420.sv
// ----------------------------------------------------------------------------
// rgb565_scaled_to_yuv420
// RGB565 raster stream to BT.601 YUV 4:2:0 with nearest-neighbor downscale.
// ----------------------------------------------------------------------------
// Accepts one RGB565 source pixel per clock while the queue is not full, in
// raster order, and emits a transaction only for pixels picked by the crop
// window and the 8.16 scale step, carrying destination x/y, luma and the
// Cb/Cr of the 2x2 chroma cell (downstream keeps the last chroma written to
// a cell). A selected pixel is registered in a four-entry queue and then
// converted combinationally into the result register, so sustained
// throughput is one pixel per clock while the result side keeps up, and the
// input stalls only once the queue is full. Configuration is written through
// the csr port; the user must write it only while idle, as the block itself
// does not enforce this.
module rgb565_scaled_to_yuv420 #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [ryc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [ryc_pkg::CSR_DATA_BITS-1:0]   csr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ryc_pkg::PIXEL_BITS-1:0]      req_pixel_word,
   input  logic                                req_frame_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ryc_pkg::COORD_BITS-1:0]      rsp_dest_x,
   output logic [ryc_pkg::COORD_BITS-1:0]      rsp_dest_y,
   output logic [7:0]                          rsp_luma,
   output logic [7:0]                          rsp_chroma_blue,
   output logic [7:0]                          rsp_chroma_red
);
   import ryc_pkg::*;

   queue_status_type queue_status;
   queue_entry_type  push_entry, head;
   logic             push_valid, pop;

   // front end: counters and selection
   ryc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_word (req_pixel_word),
      .req_frame_last (req_frame_last),
      .queue_status   (queue_status),
      .push_valid     (push_valid),
      .push_entry     (push_entry)
   );

   // decoupling queue
   ryc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .status     (queue_status),
      .pop        (pop),
      .head       (head)
   );

   // back end: color conversion and result register
   ryc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_status    (queue_status),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_dest_x      (rsp_dest_x),
      .rsp_dest_y      (rsp_dest_y),
      .rsp_luma        (rsp_luma),
      .rsp_chroma_blue (rsp_chroma_blue),
      .rsp_chroma_red  (rsp_chroma_red)
   );

endmodule

FILE: src/ryc_checker.sv
// ----------------------------------------------------------------------------
// ryc_checker
// Port-level checks of the scaler, bound to the top level.
// ----------------------------------------------------------------------------
module ryc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [7:0]                          rsp_luma,
   input logic [7:0]                          rsp_chroma_blue,
   input logic [7:0]                          rsp_chroma_red
);

   // no result right after reset
   assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // luma of any rgb565 pixel lies in 16..231
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_luma >= 8'd16) && (rsp_luma <= 8'd231))
      else $error("luma out of range");

   // chroma of any rgb565 pixel lies in 18..237
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_chroma_blue >= 8'd18) && (rsp_chroma_blue <= 8'd237)
                 && (rsp_chroma_red >= 8'd18) && (rsp_chroma_red <= 8'd237))
      else $error("chroma out of range");

endmodule

bind rgb565_scaled_to_yuv420 ryc_checker u_checker (.*);
